// ----- design/l2c_pkg.sv -----
// ----------------------------------------------------------------------------
// l2c_pkg: shared types and constants for the LBA to CHS converter
// Widths, register indexes and the word carried by each divider stage.
// ----------------------------------------------------------------------------
package l2c_pkg;

    // field widths
    localparam int LBA_W    = 32;
    localparam int SEC_W    = 6;
    localparam int HEAD_W   = 8;
    localparam int CYL_W    = 16;
    localparam int REM_W    = 8;   // remainder; divisors never exceed 255

    // divider pipeline: quotient bits resolved in each stage
    localparam int BITS_PER_STAGE = 8;
    localparam int STAGES_PER_DIV = LBA_W / BITS_PER_STAGE;
    localparam int NUM_STAGES     = 2 * STAGES_PER_DIV;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADS = 8'd1;

    localparam logic [SEC_W-1:0]  SPT_RESET   = 6'd63;
    localparam logic [HEAD_W-1:0] HEADS_RESET = 8'd255;
    localparam logic [CYL_W-1:0]  CYL_MAX     = 16'hFFFF;

    // partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [LBA_W-1:0] quo;
    } div_word_t;

    // fields riding alongside the division
    typedef struct packed {
        logic             opcode;
        logic [SEC_W-1:0] sector;   // zero-based sector, valid after first divide
    } side_t;

endpackage

// ----- design/l2c_div_stage.sv -----
// ----------------------------------------------------------------------------
// l2c_div_stage: one restoring-division stage
// Resolves BITS_PER_STAGE quotient bits per beat and registers the result.
// ----------------------------------------------------------------------------
module l2c_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              in_valid,
    input  l2c_pkg::div_word_t in_word,
    input  l2c_pkg::side_t    in_side,
    input  logic [l2c_pkg::REM_W-1:0] divisor,
    output logic              out_valid,
    output l2c_pkg::div_word_t out_word,
    output l2c_pkg::side_t    out_side
);
    import l2c_pkg::*;

    logic      valid_reg;
    div_word_t word_reg;
    div_word_t word_next;
    side_t     side_reg;

    // shift-subtract steps, MSB of the dividend first
    always_comb begin
        logic [REM_W:0]   partial;
        logic [REM_W-1:0] rem;
        logic [LBA_W-1:0] quo;
        rem = in_word.rem;
        quo = in_word.quo;
        for (int i = 0; i < BITS_PER_STAGE; i++) begin
            partial = {rem, quo[LBA_W-1]};
            if (partial >= {1'b0, divisor}) begin
                partial = partial - {1'b0, divisor};
                quo     = {quo[LBA_W-2:0], 1'b1};
            end else begin
                quo     = {quo[LBA_W-2:0], 1'b0};
            end
            rem = partial[REM_W-1:0];
        end
        word_next.rem = rem;
        word_next.quo = quo;
    end

    // valid cleared on reset, payload loads whenever the pipe moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            word_reg <= word_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign out_side  = side_reg;

endmodule

// ----- design/lba_to_chs_converter.sv -----
// ----------------------------------------------------------------------------
// lba_to_chs_converter: logical sector number to cylinder/head/sector
// Two pipelined restoring dividers: by sectors per track, then by head count.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / data               | tuser
//  s_       | in        | logical_sector[31:0]       | opcode
//  m_       | out       | sector, head, cyl, ovf     | access_kind
//  cfg_     | in        | index 0 spt, 1 heads       | -
//
//  One beat per cycle in and out unless m_ stalls; 8 divider stages (each
//  resolving 8 quotient bits, two 32-bit quotients) feed the output register.
//  Reset clears the valid bits and loads 63 sectors per track, 255 heads.
//  A stall on m_ freezes the whole pipeline; s_tready follows it.
//  The divisors feed every stage directly, so configuration must be written only
//  while the pipeline is empty; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lba_to_chs_converter (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [l2c_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [l2c_pkg::CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] logical_sector
    input  logic                           s_tuser,   // [0] opcode
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [5:0] sector_number,
                                                      // [13:6] head_number,
                                                      // [29:14] cylinder_number,
                                                      // [30] cylinder_overflow,
                                                      // [31] zero
    output logic                           m_tuser    // [0] access_kind
);
    import l2c_pkg::*;

    localparam int OUT_W   = SEC_W + HEAD_W + CYL_W + 1;
    localparam int TDATA_W = 32;

    logic [SEC_W-1:0]  spt_reg;
    logic [HEAD_W-1:0] heads_reg;
    logic [REM_W-1:0]  spt_div;
    logic [REM_W-1:0]  heads_div;

    logic advance;

    logic      st_in_valid  [NUM_STAGES];
    div_word_t st_in_word   [NUM_STAGES];
    side_t     st_in_side   [NUM_STAGES];
    logic      st_out_valid [NUM_STAGES];
    div_word_t st_out_word  [NUM_STAGES];
    side_t     st_out_side  [NUM_STAGES];

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic [OUT_W-1:0]   out_data_next;
    logic               out_kind_reg;

    logic [SEC_W-1:0]   sec_one;
    logic               cyl_ovf;
    logic [CYL_W-1:0]   cyl_sat;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg   <= SPT_RESET;
            heads_reg <= HEADS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_SPT:   spt_reg   <= cfg_data[SEC_W-1:0];
                CFG_IDX_HEADS: heads_reg <= cfg_data[HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero divisor behaves as one
    assign spt_div   = (spt_reg == '0) ? REM_W'(1) : REM_W'(spt_reg);
    assign heads_div = (heads_reg == '0) ? REM_W'(1) : heads_reg;

    // whole pipe moves unless the result register is full and held
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    // divider chain
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_entry
            assign st_in_valid[g]       = s_tvalid;
            assign st_in_word[g].rem    = '0;
            assign st_in_word[g].quo    = s_tdata;
            assign st_in_side[g].opcode = s_tuser;
            assign st_in_side[g].sector = '0;
        end else if (g == STAGES_PER_DIV) begin : g_handover
            // remainder of the first divide is the sector; quotient is the track
            assign st_in_valid[g]       = st_out_valid[g-1];
            assign st_in_word[g].rem    = '0;
            assign st_in_word[g].quo    = st_out_word[g-1].quo;
            assign st_in_side[g].opcode = st_out_side[g-1].opcode;
            assign st_in_side[g].sector = st_out_word[g-1].rem[SEC_W-1:0];
        end else begin : g_chain
            assign st_in_valid[g] = st_out_valid[g-1];
            assign st_in_word[g]  = st_out_word[g-1];
            assign st_in_side[g]  = st_out_side[g-1];
        end

        l2c_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (st_in_valid[g]),
            .in_word   (st_in_word[g]),
            .in_side   (st_in_side[g]),
            .divisor   ((g < STAGES_PER_DIV) ? spt_div : heads_div),
            .out_valid (st_out_valid[g]),
            .out_word  (st_out_word[g]),
            .out_side  (st_out_side[g])
        );
    end

    // final formatting: one-based sector, saturated cylinder
    assign sec_one = st_out_side[NUM_STAGES-1].sector + SEC_W'(1);
    assign cyl_ovf = |st_out_word[NUM_STAGES-1].quo[LBA_W-1:CYL_W];
    assign cyl_sat = cyl_ovf ? CYL_MAX : st_out_word[NUM_STAGES-1].quo[CYL_W-1:0];
    assign out_data_next = {cyl_ovf, cyl_sat,
                            st_out_word[NUM_STAGES-1].rem[HEAD_W-1:0], sec_one};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= st_out_valid[NUM_STAGES-1];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            out_kind_reg <= st_out_side[NUM_STAGES-1].opcode;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-OUT_W){1'b0}}, out_data_reg};
    assign m_tuser  = out_kind_reg;

`ifndef NO_ASSERTIONS
    // valid bits clear out of reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input side only stalls when the result register is held
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not track the output stall");

    // overflow always comes with a saturated cylinder
    a_ovf_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30] |-> m_tdata[29:14] == CYL_MAX)
        else $error("overflow without saturated cylinder");

    // held result stays put
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
`endif

endmodule

// ----- tb/sv/tb_lba_to_chs_converter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lba_to_chs_converter: self-checking bench for the LBA to CHS converter
// A short table of directed sector requests is followed by random phases,
// each with its own geometry written over the configuration port. Each beat
// accepted on s_ takes its expected result from the table or, failing that,
// from a behavioural model of the geometry split. Each beat on m_ is compared
// in order against those results. Both sides idle at random, and once the
// result side holds off long enough to back the pipeline up into s_tready.
// ----------------------------------------------------------------------------
module tb_lba_to_chs_converter;
    import l2c_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;   // covers the divider stages and output register, leave some margin

    // one translated address, fields in port order
    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [HEAD_W-1:0] head;
        logic [CYL_W-1:0]  cyl;
        logic              ovf;
        logic              kind;
    } chs_t;

    // directed stimulus row: geometry to run under, request, optional answer
    typedef struct {
        logic [CFG_DATA_W-1:0] spt_raw;
        logic [CFG_DATA_W-1:0] heads_raw;
        logic [LBA_W-1:0]      lba;
        logic                  op;
        bit                    typed;
        chs_t                  want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [31:0] logical_sector
    logic                  s_tuser   = 1'b0; // [0] opcode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;          // [5:0] sector, [13:6] head,
                                             // [29:14] cylinder, [30] overflow
    logic                  m_tuser;          // [0] access_kind

    // geometry as the block should hold it
    logic [SEC_W-1:0]      spt_cfg   = SPT_RESET;
    logic [HEAD_W-1:0]     heads_cfg = HEADS_RESET;
    logic [CFG_DATA_W-1:0] spt_raw_last   = 8'd63;
    logic [CFG_DATA_W-1:0] heads_raw_last = 8'd255;

    chs_t     chs_pending[$];
    dir_row_t dir_rows[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       tx_idle_en = 1'b1;
    bit       rx_idle_en = 1'b1;
    bit       pressure_go = 1'b0;
    bit       hold_off = 1'b0;
    int       rx_stall = 0;

    lba_to_chs_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // geometry split: sector within track, head within cylinder, cylinder
    function automatic chs_t chs_of(input logic [LBA_W-1:0] lba, input logic op);
        chs_t        r;
        int unsigned d_sec, d_head, track, cyl;
        d_sec  = (spt_cfg == '0) ? 1 : spt_cfg;     // zero divisor acts as one
        d_head = (heads_cfg == '0) ? 1 : heads_cfg;
        r.sec  = SEC_W'(lba % d_sec + 1);
        track  = lba / d_sec;
        r.head = HEAD_W'(track % d_head);
        cyl    = track / d_head;
        if (cyl > CYL_MAX) begin
            r.cyl = CYL_MAX;
            r.ovf = 1'b1;
        end else begin
            r.cyl = CYL_W'(cyl);
            r.ovf = 1'b0;
        end
        r.kind = op;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // raw register data, weighted towards zero, one and all-ones
    function automatic logic [CFG_DATA_W-1:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'hFF;
            default: return CFG_DATA_W'($urandom_range(0, 255));
        endcase
    endfunction

    // sector numbers: random, below, on and around the cylinder saturation point, and edge cases
    function automatic logic [LBA_W-1:0] pick_lba();
        longint unsigned per_cyl, sat_lba, k;
        int unsigned     d_sec, d_head;
        d_sec   = (spt_cfg == '0) ? 1 : spt_cfg;
        d_head  = (heads_cfg == '0) ? 1 : heads_cfg;
        per_cyl = longint'(d_sec) * d_head;
        sat_lba = per_cyl * 65536;              // first sector past cylinder 65535
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3, 4, 5: return $urandom_range(0, 32'(sat_lba - 1));
            6, 7:    return 32'(sat_lba) + $urandom_range(0, 7) - 32'd4;
            8: begin
                k = $urandom_range(0, 70000);
                case ($urandom_range(0, 2))
                    0: return 32'(k * per_cyl);
                    1: return 32'(k * per_cyl + d_sec - 1);
                    default: return 32'(k * per_cyl + per_cyl - 1);
                endcase
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return 32'd1 << $urandom_range(0, 31);
                endcase
            end
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        // unknown indexes leave the geometry alone
        if (idx == CFG_IDX_SPT) begin
            spt_cfg      = data[SEC_W-1:0];
            spt_raw_last = data;
        end else if (idx == CFG_IDX_HEADS) begin
            heads_cfg      = data;
            heads_raw_last = data;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering and let every outstanding result come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chs_pending.size() != 0) @(posedge aclk);
    endtask

    task automatic send_sector(input logic [LBA_W-1:0] lba, input logic op,
                               input bit typed, input chs_t want);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= lba;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        chs_pending.push_back(typed ? want : chs_of(lba, op));
    endtask

    task automatic add_row(input logic [7:0] spt_raw, input logic [7:0] heads_raw,
                           input logic [31:0] lba, input logic op, input bit typed,
                           input logic [5:0] sec, input logic [7:0] head,
                           input logic [15:0] cyl, input logic ovf);
        dir_row_t row;
        row.spt_raw   = spt_raw;
        row.heads_raw = heads_raw;
        row.lba       = lba;
        row.op        = op;
        row.typed     = typed;
        row.want      = '{sec, head, cyl, ovf, op};
        dir_rows.push_back(row);
    endtask

    task automatic note_fail(input string what, input chs_t want, input chs_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: exp sec=%0d head=%0d cyl=%0d ovf=%0b kind=%0b, got sec=%0d head=%0d cyl=%0d ovf=%0b kind=%0b",
                     what, want.sec, want.head, want.cyl, want.ovf, want.kind,
                     got.sec, got.head, got.cyl, got.ovf, got.kind);
    endtask

    // result side readiness: random stalls, plus the long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off || !aresetn) begin
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
                rx_stall = pick_gap();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // long hold-off on m_, counted here so the sender keeps pushing meanwhile
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // result check against the oldest outstanding translation
    always @(posedge aclk) begin
        chs_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[5:0], m_tdata[13:6], m_tdata[29:14], m_tdata[30], m_tuser};
            if (chs_pending.size() == 0) begin
                note_fail("unexpected beat", '0, got);
            end else begin
                want = chs_pending.pop_front();
                if (got !== want) note_fail("mismatch", want, got);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial begin
        // reset geometry first, then divider edges and the zero divisors
        add_row(8'd63, 8'd255, 32'd0,          1'b0, 1, 6'd1,  8'd0,   16'd0,     1'b0);
        add_row(8'd63, 8'd255, 32'd0,          1'b1, 1, 6'd1,  8'd0,   16'd0,     1'b0);
        add_row(8'd63, 8'd255, 32'd62,         1'b0, 1, 6'd63, 8'd0,   16'd0,     1'b0);
        add_row(8'd63, 8'd255, 32'd63,         1'b1, 1, 6'd1,  8'd1,   16'd0,     1'b0);
        add_row(8'd63, 8'd255, 32'd16064,      1'b0, 1, 6'd63, 8'd254, 16'd0,     1'b0);
        add_row(8'd63, 8'd255, 32'd16065,      1'b1, 1, 6'd1,  8'd0,   16'd1,     1'b0);
        add_row(8'd63, 8'd255, 32'hFFFF_FFFF,  1'b1, 0, 6'd0,  8'd0,   16'd0,     1'b0);
        add_row(8'd63, 8'd255, 32'd1052835839, 1'b0, 1, 6'd63, 8'd254, 16'hFFFF,  1'b0);
        add_row(8'd63, 8'd255, 32'd1052835840, 1'b1, 1, 6'd1,  8'd0,   16'hFFFF,  1'b1);
        add_row(8'd0,  8'd0,   32'h0000_FFFF,  1'b0, 1, 6'd1,  8'd0,   16'hFFFF,  1'b0);
        add_row(8'd0,  8'd0,   32'h0001_0000,  1'b0, 1, 6'd1,  8'd0,   16'hFFFF,  1'b1);
        add_row(8'd0,  8'd0,   32'hFFFF_FFFF,  1'b1, 1, 6'd1,  8'd0,   16'hFFFF,  1'b1);
        add_row(8'd1,  8'd1,   32'd12345,      1'b0, 1, 6'd1,  8'd0,   16'd12345, 1'b0);
        add_row(8'd1,  8'd255, 32'hAAAA_AAAA,  1'b1, 0, 6'd0,  8'd0,   16'd0,     1'b0);
        add_row(8'd63, 8'd1,   32'h5555_5555,  1'b0, 0, 6'd0,  8'd0,   16'd0,     1'b0);
        add_row(8'hFF, 8'd0,   32'h0765_4321,  1'b1, 0, 6'd0,  8'd0,   16'd0,     1'b0);
        add_row(8'hC5, 8'h80,  32'h0123_4567,  1'b0, 0, 6'd0,  8'd0,   16'd0,     1'b0);
        add_row(8'd7,  8'd3,   32'hDEAD_BEEF,  1'b1, 0, 6'd0,  8'd0,   16'd0,     1'b0);
        add_row(8'd2,  8'd254, 32'h1234_5678,  1'b0, 0, 6'd0,  8'd0,   16'd0,     1'b0);
        add_row(8'd40, 8'd16,  32'd0,          1'b1, 1, 6'd1,  8'd0,   16'd0,     1'b0);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].spt_raw != spt_raw_last ||
                dir_rows[i].heads_raw != heads_raw_last) begin
                settle();
                write_reg(CFG_IDX_SPT, dir_rows[i].spt_raw);
                write_reg(CFG_IDX_HEADS, dir_rows[i].heads_raw);
            end
            send_sector(dir_rows[i].lba, dir_rows[i].op, dir_rows[i].typed,
                        dir_rows[i].want);
        end

        // random phases, each under its own geometry
        for (int p = 0; p < PHASES; p++) begin
            settle();
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            case (p)
                0: begin
                    // writes to indexes outside the register list must be dropped
                    write_reg(CFG_IDX_HEADS + 8'd1, 8'h00);
                    write_reg(8'hFF, 8'h00);
                end
                1: begin
                    write_reg(CFG_IDX_SPT, 8'd1);
                    write_reg(CFG_IDX_HEADS, 8'd1);
                end
                2: begin
                    write_reg(CFG_IDX_HEADS, 8'd255);
                    write_reg(CFG_IDX_SPT, 8'd63);
                    tx_idle_en  = 1'b0;
                    pressure_go = 1'b1;
                end
                3: begin
                    write_reg(CFG_IDX_SPT, 8'd0);
                    write_reg(CFG_IDX_HEADS, 8'd0);
                end
                default: begin
                    write_reg(CFG_IDX_SPT, pick_raw());
                    write_reg(CFG_IDX_HEADS, pick_raw());
                end
            endcase
            repeat (PHASE_ITEMS) send_sector(pick_lba(), logic'($urandom_range(0, 1)),
                                             0, '0);
        end

        // drain, then allow for anything the block might still emit
        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && chs_pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
design/l2c_pkg.sv
design/l2c_div_stage.sv
design/lba_to_chs_converter.sv
tb/sv/tb_lba_to_chs_converter.sv
